// ===== rtl/pssq_pkg.sv =====
// Shared types, codes and lookup functions for the pot stepper mode sequencer.
package pssq_pkg;

    localparam int SAMPLE_W = 10;
    localparam int THRESH_W = 10;
    localparam int HOLD_W   = 8;
    localparam int LEVEL_W  = 4;
    localparam int SEG_W    = 8;
    localparam int PHASE_W  = 4;
    localparam int IDX_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COUNT     = 2'd2;

    localparam logic [THRESH_W-1:0] HIGH_THRESHOLD_RST = 10'd600;
    localparam logic [THRESH_W-1:0] LOW_THRESHOLD_RST  = 10'd400;
    localparam logic [HOLD_W-1:0]   HOLD_COUNT_RST     = 8'd10;

    // run kinds
    localparam logic [1:0] RUN_FULL_CW  = 2'd0;
    localparam logic [1:0] RUN_FULL_CCW = 2'd1;
    localparam logic [1:0] RUN_HALF_CW  = 2'd2;
    localparam logic [1:0] RUN_HALF_CCW = 2'd3;

    localparam logic [IDX_W-1:0] FULL_LAST_IDX = 3'd3;
    localparam logic [IDX_W-1:0] HALF_LAST_IDX = 3'd7;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [1:0]       kind;
        logic             level_up;
    } t_run;

    function automatic logic [SEG_W-1:0] seg_lookup(input logic [LEVEL_W-1:0] lvl);
        logic [SEG_W-1:0] seg;
        unique case (lvl)
            4'd0:    seg = 8'hfc;
            4'd1:    seg = 8'h60;
            4'd2:    seg = 8'hda;
            4'd3:    seg = 8'hf2;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'hb6;
            4'd6:    seg = 8'hbe;
            4'd7:    seg = 8'he0;
            4'd8:    seg = 8'hfe;
            default: seg = 8'hf6;   // nine and above
        endcase
        return seg;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_lookup(input logic [1:0] kind,
                                                        input logic [IDX_W-1:0] idx);
        logic [PHASE_W-1:0] ph;
        ph = '0;
        unique case (kind)
            RUN_FULL_CW: begin
                unique case (idx[1:0])
                    2'd0:    ph = 4'h1;
                    2'd1:    ph = 4'h2;
                    2'd2:    ph = 4'h4;
                    default: ph = 4'h8;
                endcase
            end
            RUN_FULL_CCW: begin
                unique case (idx[1:0])
                    2'd0:    ph = 4'h8;
                    2'd1:    ph = 4'h4;
                    2'd2:    ph = 4'h2;
                    default: ph = 4'h1;
                endcase
            end
            RUN_HALF_CW: begin
                unique case (idx)
                    3'd0:    ph = 4'h9;
                    3'd1:    ph = 4'h1;
                    3'd2:    ph = 4'h3;
                    3'd3:    ph = 4'h2;
                    3'd4:    ph = 4'h6;
                    3'd5:    ph = 4'h4;
                    3'd6:    ph = 4'hc;
                    default: ph = 4'h8;
                endcase
            end
            default: begin
                unique case (idx)
                    3'd0:    ph = 4'h8;
                    3'd1:    ph = 4'hc;
                    3'd2:    ph = 4'h4;
                    3'd3:    ph = 4'h6;
                    3'd4:    ph = 4'h2;
                    3'd5:    ph = 4'h3;
                    3'd6:    ph = 4'h1;
                    default: ph = 4'h9;
                endcase
            end
        endcase
        return ph;
    endfunction

endpackage

// ===== rtl/pssq_level_ctrl.sv =====
// Hold counter and speed level state, updated once per loaded sample.
module pssq_level_ctrl
    import pssq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [THRESH_W-1:0] i_high_threshold,
    input  logic [THRESH_W-1:0] i_low_threshold,
    input  logic [HOLD_W-1:0]   i_hold_count,
    output t_run                o_run
);

    logic [LEVEL_W-1:0] r_level;
    logic [HOLD_W-1:0]  r_counter;
    logic [LEVEL_W-1:0] n_level;
    logic [HOLD_W-1:0]  n_counter;

    logic               above;
    logic               below;
    logic [HOLD_W:0]    cnt_inc;
    logic               fire;
    logic [LEVEL_W-1:0] lvl_raw;

    always_comb begin
        above   = i_sample > i_high_threshold;
        below   = i_sample < i_low_threshold;
        cnt_inc = {1'b0, r_counter} + {{HOLD_W{1'b0}}, 1'b1};
        fire    = (above || below) && (cnt_inc > {1'b0, i_hold_count});

        lvl_raw = r_level;
        if (fire && above) begin
            if (r_level != {LEVEL_W{1'b1}}) lvl_raw = r_level + 4'd1;
        end else if (fire) begin
            if (r_level != '0) lvl_raw = r_level - 4'd1;
        end

        if (fire)                n_counter = '0;
        else if (above || below) n_counter = cnt_inc[HOLD_W-1:0];
        else                     n_counter = r_counter;

        // clamp into the run range
        if (lvl_raw > 4'd8)      n_level = 4'd6;
        else if (lvl_raw == '0)  n_level = 4'd1;
        else                     n_level = lvl_raw;

        o_run.segments = seg_lookup(lvl_raw);
        o_run.level_up = fire && above;
        if (n_level > 4'd5)      o_run.kind = RUN_FULL_CW;
        else if (n_level < 4'd2) o_run.kind = RUN_FULL_CCW;
        else if (n_level >= 4'd4) o_run.kind = RUN_HALF_CW;
        else                     o_run.kind = RUN_HALF_CCW;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_counter <= '0;
        end else if (i_load) begin
            r_level   <= n_level;
            r_counter <= n_counter;
        end
    end

endmodule

// ===== rtl/pssq_phase_gen.sv =====
// Run register: plays out the phases of one run, one word per cycle unless stalled.
module pssq_phase_gen
    import pssq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_run               i_run,
    input  logic               i_stall,
    output logic               o_valid,
    output logic               o_last,
    output logic               o_done,
    output logic [SEG_W-1:0]   o_segments,
    output logic [PHASE_W-1:0] o_phase,
    output logic               o_level_up
);

    logic             r_valid;
    t_run             r_run;
    logic [IDX_W-1:0] r_idx;
    logic             fire;

    always_comb begin
        o_last = (r_run.kind == RUN_FULL_CW || r_run.kind == RUN_FULL_CCW)
                 ? (r_idx == FULL_LAST_IDX) : (r_idx == HALF_LAST_IDX);
        fire   = r_valid && !i_stall;
        // free to take a new run: empty, or final word leaving now
        o_done = !r_valid || (fire && o_last);
    end

    assign o_valid    = r_valid;
    assign o_segments = r_run.segments;
    assign o_level_up = r_run.level_up;
    assign o_phase    = phase_lookup(r_run.kind, r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (fire) begin
            if (o_last) r_valid <= 1'b0;
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_run <= i_run;
    end

endmodule

// ===== rtl/pot_stepper_mode_sequencer.sv =====
// Top level of the pot stepper mode sequencer.
// Each accepted ADC sample word updates a shared hold counter and the speed
// level, then produces a run of 4 full-step or 8 half-step stepper phase
// words, one per cycle unless stalled, each carrying the seven-segment code
// of the level and a level_up flag; o_last marks the final word of a run.
// Throughput is set by the phase run register: one sample per run with no
// stall downstream. One sample is held in an input register while a run
// plays out, so the next word is taken while the run still drains; the level
// update is a single combinational pass done when the held sample moves into
// the run register. Configuration (thresholds, hold count) is written via
// i_cfg_we/i_cfg_idx/i_cfg_data only while idle: a user rule the block does not enforce.
module pot_stepper_mode_sequencer
    import pssq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample word in
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    // phase word out
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SEG_W-1:0]      o_segments,
    output logic [PHASE_W-1:0]    o_phase,
    output logic                  o_level_up,
    output logic                  o_last,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [THRESH_W-1:0] r_high_threshold;
    logic [THRESH_W-1:0] r_low_threshold;
    logic [HOLD_W-1:0]   r_hold_count;

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;

    logic                load;
    logic                run_done;
    t_run                run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_threshold <= HIGH_THRESHOLD_RST;
            r_low_threshold  <= LOW_THRESHOLD_RST;
            r_hold_count     <= HOLD_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HIGH_THRESHOLD: r_high_threshold <= i_cfg_data;
                CFG_LOW_THRESHOLD:  r_low_threshold  <= i_cfg_data;
                CFG_HOLD_COUNT:     r_hold_count     <= i_cfg_data[HOLD_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // held sample moves on when the run register frees up
    assign load    = r_in_valid && run_done;
    assign o_stall = r_in_valid && !run_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) r_in_sample <= i_sample;
    end

    pssq_level_ctrl u_level_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (load),
        .i_sample         (r_in_sample),
        .i_high_threshold (r_high_threshold),
        .i_low_threshold  (r_low_threshold),
        .i_hold_count     (r_hold_count),
        .o_run            (run)
    );

    pssq_phase_gen u_phase_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_run      (run),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_last     (o_last),
        .o_done     (run_done),
        .o_segments (o_segments),
        .o_phase    (o_phase),
        .o_level_up (o_level_up)
    );

endmodule

// ===== dv/tb_pot_stepper_mode_sequencer.sv =====
// Self-checking testbench for the pot stepper mode sequencer.
`timescale 1ns / 1ps

module tb_pot_stepper_mode_sequencer
    import pssq_pkg::*;
();

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    logic [SAMPLE_W-1:0]   i_sample   = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    logic [SEG_W-1:0]      o_segments;
    logic [PHASE_W-1:0]    o_phase;
    logic                  o_level_up;
    logic                  o_last;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pot_stepper_mode_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_sample   (i_sample),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_segments (o_segments),
        .o_phase    (o_phase),
        .o_level_up (o_level_up),
        .o_last     (o_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Tables. Entry 0 sits in the low bits of each vector.
    // Display codes for levels 0..9, and the four coil sequences.
    // ------------------------------------------------------------------
    localparam logic [10*SEG_W-1:0] DIGIT_CODES = 80'hf6_fe_e0_be_b6_66_f2_da_60_fc;
    localparam logic [31:0] FULL_CW_STEPS  = 32'h0000_8421;
    localparam logic [31:0] FULL_CCW_STEPS = 32'h0000_1248;
    localparam logic [31:0] HALF_CW_STEPS  = 32'h8c46_2319;
    localparam logic [31:0] HALF_CCW_STEPS = 32'h9132_64c8;

    typedef struct packed {
        logic [SEG_W-1:0]   segments;
        logic [PHASE_W-1:0] phase;
        logic               level_up;
        logic               last;
    } t_phase_word;

    // ------------------------------------------------------------------
    // Shadow copy of the block: registers and state
    // ------------------------------------------------------------------
    logic [THRESH_W-1:0] high_thr  = HIGH_THRESHOLD_RST;
    logic [THRESH_W-1:0] low_thr   = LOW_THRESHOLD_RST;
    logic [HOLD_W-1:0]   hold_lim  = HOLD_COUNT_RST;
    logic [LEVEL_W-1:0]  speed_lvl = '0;
    logic [HOLD_W-1:0]   hold_cnt  = '0;

    logic [SAMPLE_W-1:0] sample_q[$];     // samples waiting for the driver
    t_phase_word         run_words_q[$];  // phase words the block still owes

    int n_errors   = 0;
    int n_samples  = 0;
    int n_words    = 0;
    int n_raises   = 0;
    int run_seen[4] = '{0, 0, 0, 0};

    // One accepted sample: update counter and level, then queue the whole
    // phase run it produces. Raising wins when both thresholds are met;
    // the counter is compared after the increment, so it never wraps.
    task automatic queue_phase_run(input logic [SAMPLE_W-1:0] smp);
        logic [HOLD_W:0]    next_cnt;
        logic               raised;
        logic [LEVEL_W-1:0] shown;
        logic [SEG_W-1:0]   seg;
        logic [1:0]         kind;
        logic [31:0]        steps;
        int                 n_steps;
        t_phase_word        w;
        raised = 1'b0;
        if (smp > high_thr || smp < low_thr) begin
            next_cnt = {1'b0, hold_cnt} + 1'b1;
            if (next_cnt > {1'b0, hold_lim}) begin
                if (smp > high_thr) begin
                    if (speed_lvl != 4'd15)
                        speed_lvl = speed_lvl + 1'b1;
                    raised = 1'b1;
                end else if (speed_lvl != 4'd0) begin
                    speed_lvl = speed_lvl - 1'b1;
                end
                hold_cnt = '0;
            end else begin
                hold_cnt = next_cnt[HOLD_W-1:0];
            end
        end
        // display shows the level before the clamp
        shown = (speed_lvl > 4'd9) ? 4'd9 : speed_lvl;
        seg   = DIGIT_CODES[shown*SEG_W +: SEG_W];
        if (speed_lvl > 4'd8)
            speed_lvl = 4'd6;
        else if (speed_lvl < 4'd1)
            speed_lvl = 4'd1;

        if (speed_lvl > 4'd5)
            kind = RUN_FULL_CW;
        else if (speed_lvl < 4'd2)
            kind = RUN_FULL_CCW;
        else if (speed_lvl >= 4'd4)
            kind = RUN_HALF_CW;
        else
            kind = RUN_HALF_CCW;

        case (kind)
            RUN_FULL_CW: begin
                steps = FULL_CW_STEPS;  n_steps = 4;
            end
            RUN_FULL_CCW: begin
                steps = FULL_CCW_STEPS; n_steps = 4;
            end
            RUN_HALF_CW: begin
                steps = HALF_CW_STEPS;  n_steps = 8;
            end
            default: begin
                steps = HALF_CCW_STEPS; n_steps = 8;
            end
        endcase

        run_seen[kind]++;
        if (raised)
            n_raises++;
        for (int k = 0; k < n_steps; k++) begin
            w.segments = seg;
            w.phase    = steps[k*PHASE_W +: PHASE_W];
            w.level_up = raised;
            w.last     = (k == n_steps - 1);
            run_words_q.push_back(w);
        end
    endtask

    // Random sample biased toward the counting regions so the level moves.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(99, 0);
        if (r < 40 && high_thr != 10'd1023)
            return SAMPLE_W'($urandom_range(1023, int'(high_thr) + 1));
        if (r < 80 && low_thr != 10'd0)
            return SAMPLE_W'($urandom_range(int'(low_thr) - 1, 0));
        return SAMPLE_W'($urandom_range(1023, 0));
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued sample words, idles ~9% of cycles except in
    // a quiet window; a stalled word is held unchanged.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                queue_phase_run(i_sample);
                n_samples++;
            end
            if (!i_valid || !o_stall) begin
                if (sample_q.size() != 0 &&
                    ((n_samples >= 120 && n_samples < 200) || $urandom_range(99, 0) >= 9)) begin
                    i_valid  <= 1'b1;
                    i_sample <= sample_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted phase word against the oldest one owed;
    // back-pressure ~9% of cycles except in a quiet window.
    // ------------------------------------------------------------------
    function automatic void report_mismatch(input string fld, input int want_v, input int got_v);
        n_errors++;
        $display("%0t: word %0d %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, n_words, fld, want_v, got_v);
    endfunction

    always @(posedge i_clk) begin
        t_phase_word want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (run_words_q.size() == 0) begin
                    n_errors++;
                    $display({"%0t: unexpected phase word, actual seg 0x%0h phase 0x%0h",
                              " up %0b last %0b"},
                             $time, o_segments, o_phase, o_level_up, o_last);
                end else begin
                    want = run_words_q.pop_front();
                    if (o_segments !== want.segments)
                        report_mismatch("segments", want.segments, o_segments);
                    if (o_phase !== want.phase)
                        report_mismatch("phase", want.phase, o_phase);
                    if (o_level_up !== want.level_up)
                        report_mismatch("level_up", want.level_up, o_level_up);
                    if (o_last !== want.last)
                        report_mismatch("last", want.last, o_last);
                end
                n_words++;
            end
            i_stall <= (n_words >= 600 && n_words < 1000) ? 1'b0 : ($urandom_range(99, 0) < 9);
        end
    end

    // ------------------------------------------------------------------
    // Register writes (only while idle) and drain helper
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_HIGH_THRESHOLD: high_thr = THRESH_W'(val);
            CFG_LOW_THRESHOLD:  low_thr  = THRESH_W'(val);
            CFG_HOLD_COUNT:     hold_lim = HOLD_W'(val);
            default: ;
        endcase
    endtask

    // wait until every queued sample is taken and every owed word is seen,
    // then give the pipeline a few spare cycles
    task automatic settle_idle();
        while (sample_q.size() != 0 || i_valid || run_words_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int hi_v;
        int lo_v;
        int hold_v;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset thresholds with an immediate hold: first sample
        // lowers from zero (shows 0, clamps to 1), eight full-scale samples
        // climb past 8 (shows 9, clamps to 6), a mid sample leaves things
        // alone, then zeros walk down through the half-step and full ccw runs to 0 again.
        cfg_write(CFG_HOLD_COUNT, 0);
        sample_q.push_back(10'd0);
        repeat (8) sample_q.push_back(10'd1023);
        sample_q.push_back(10'd500);
        repeat (6) sample_q.push_back(10'd0);
        settle_idle();

        // Overlapping thresholds: a sample meeting both must raise.
        cfg_write(CFG_HIGH_THRESHOLD, 100);
        cfg_write(CFG_LOW_THRESHOLD, 900);
        sample_q.push_back(10'd500);
        sample_q.push_back(10'd50);
        sample_q.push_back(10'd950);
        settle_idle();

        // Widest hold: every sample counts, so the level moves only on the
        // 256th counting sample after the counter last cleared.
        cfg_write(CFG_HIGH_THRESHOLD, 0);
        cfg_write(CFG_LOW_THRESHOLD, 1023);
        cfg_write(CFG_HOLD_COUNT, 255);
        repeat (260) sample_q.push_back(SAMPLE_W'($urandom_range(1023, 0)));
        settle_idle();

        // Thresholds at the far ends: nothing can count.
        cfg_write(CFG_HIGH_THRESHOLD, 1023);
        cfg_write(CFG_LOW_THRESHOLD, 0);
        cfg_write(CFG_HOLD_COUNT, 0);
        repeat (16) sample_q.push_back(pick_sample());
        settle_idle();

        // Random settings with short holds so the level wanders.
        repeat (5) begin
            hi_v   = $urandom_range(900, 100);
            lo_v   = $urandom_range(800, 50);
            hold_v = $urandom_range(3, 0);
            cfg_write(CFG_HIGH_THRESHOLD, hi_v);
            cfg_write(CFG_LOW_THRESHOLD, lo_v);
            cfg_write(CFG_HOLD_COUNT, hold_v);
            repeat (16) sample_q.push_back(pick_sample());
            settle_idle();
        end

        repeat (16) @(posedge i_clk);
        $display("checked %0d phase words from %0d samples, %0d level raises",
                 n_words, n_samples, n_raises);
        $display("runs seen: full cw %0d, full ccw %0d, half cw %0d, half ccw %0d",
                 run_seen[RUN_FULL_CW], run_seen[RUN_FULL_CCW],
                 run_seen[RUN_HALF_CW], run_seen[RUN_HALF_CCW]);
        if (n_errors == 0)
            $display("pot_stepper_mode_sequencer regression: pass");
        else
            $display("pot_stepper_mode_sequencer regression: fail");
        $finish;
    end

    // hard stop if the run hangs
    initial begin
        #2000000;
        $display("timeout with %0d words still owed", run_words_q.size());
        $display("pot_stepper_mode_sequencer regression: fail");
        $finish;
    end

endmodule

// ===== pot_stepper_mode_sequencer.f =====
rtl/pssq_pkg.sv
rtl/pssq_level_ctrl.sv
rtl/pssq_phase_gen.sv
rtl/pot_stepper_mode_sequencer.sv
dv/tb_pot_stepper_mode_sequencer.sv
